FILE: src/sitc_pkg.sv
// shared types and constants for the spiral index to coordinate unit
// no dependencies
`timescale 1ns / 1ps

package sitc_pkg;

  localparam int CoordWidth = 17;

  typedef logic signed [CoordWidth-1:0] coord_t;

endpackage

FILE: src/sitc_if.sv
// valid/ready channel interfaces for spiral indices and grid coordinates
// depends on sitc_pkg for the coordinate type
`timescale 1ns / 1ps

interface sitc_index_if #(
  parameter int INDEX_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [INDEX_WIDTH-1:0] index;

  modport source (output valid, output index, input ready);
  modport sink (input valid, input index, output ready);
endinterface

interface sitc_coord_if;
  logic            valid;
  logic            ready;
  sitc_pkg::coord_t x_coord;
  sitc_pkg::coord_t y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

FILE: src/sitc_isqrt_pipe.sv
// pipelined integer square root, one root bit per register stage
// gives root and remainder (index - root*root); no package dependencies
`timescale 1ns / 1ps

module sitc_isqrt_pipe #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           idx_valid,
  input  logic [INDEX_WIDTH-1:0]         index,
  output logic                           root_valid,
  output logic [(INDEX_WIDTH+1)/2-1:0]   root,
  output logic [(INDEX_WIDTH+1)/2:0]     rem
);

  localparam int RootW = (INDEX_WIDTH + 1) / 2;
  localparam int PadW  = 2 * RootW;
  localparam int TrialW = RootW + 3;

  logic               st_v [RootW];
  logic [RootW-1:0]   st_q [RootW];
  logic [RootW:0]     st_r [RootW];
  logic [PadW-1:0]    st_n [RootW];

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    logic              prev_v;
    logic [RootW-1:0]  prev_q;
    logic [RootW:0]    prev_r;
    logic [PadW-1:0]   prev_n;
    logic [TrialW-1:0] rp;
    logic [TrialW-1:0] trial;
    logic [TrialW-1:0] diff;
    logic              ge;
    logic [RootW-1:0]  q_next;
    logic [RootW:0]    r_next;
    logic [PadW-1:0]   n_next;

    if (s == 0) begin : g_first
      assign prev_v = idx_valid;
      assign prev_q = '0;
      assign prev_r = '0;
      assign prev_n = PadW'(index);
    end else begin : g_rest
      assign prev_v = st_v[s-1];
      assign prev_q = st_q[s-1];
      assign prev_r = st_r[s-1];
      assign prev_n = st_n[s-1];
    end

    // bring down the next bit pair and try appending a one to the root
    always_comb begin
      rp     = {prev_r, prev_n[PadW-1 -: 2]};
      trial  = {1'b0, prev_q, 2'b01};
      diff   = rp - trial;
      ge     = (rp >= trial);
      r_next = ge ? diff[RootW:0] : rp[RootW:0];
      q_next = {prev_q[RootW-2:0], ge};
      n_next = {prev_n[PadW-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[s] <= 1'b0;
      end else if (en) begin
        st_v[s] <= prev_v;
      end
      if (en) begin
        st_q[s] <= q_next;
        st_r[s] <= r_next;
        st_n[s] <= n_next;
      end
    end
  end

  assign root_valid = st_v[RootW-1];
  assign root       = st_q[RootW-1];
  assign rem        = st_r[RootW-1];

  // remainder of an integer square root never exceeds twice the root
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    root_valid |-> (rem <= {root, 1'b0}))
    else $error("isqrt remainder above 2*root");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!en && root_valid) |=> (root_valid && $stable(root) && $stable(rem)))
    else $error("isqrt result changed during stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!st_v[0] && !root_valid))
    else $error("isqrt pipeline not empty after reset");

endmodule

FILE: src/spiral_index_to_coordinate_unit.sv
// spiral index to (x,y) grid coordinate, 1 at the origin, up positive
// registered through the square root stages (one root bit per stage) and then an output register
// throughput: one transaction per cycle; all stages advance together, a stall holds them
// reset (rst, synchronous): clears every stage valid bit, no transaction in flight
// depends on sitc_pkg, sitc_if and sitc_isqrt_pipe
`timescale 1ns / 1ps

module spiral_index_to_coordinate_unit #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  sitc_index_if.sink  index_ch,
  sitc_coord_if.source coord_ch
);

  import sitc_pkg::*;

  localparam int RootW = (INDEX_WIDTH + 1) / 2;
  localparam int ExtW  = (RootW + 2 > CoordWidth) ? RootW + 2 : CoordWidth;

  logic             en;
  logic             root_valid;
  logic [RootW-1:0] root;
  logic [RootW:0]   rem;

  logic             out_v;
  coord_t           x_reg;
  coord_t           y_reg;
  coord_t           x_next;
  coord_t           y_next;

  logic [ExtW-1:0]  half_ext;
  logic [ExtW-1:0]  len_ext;
  logic [RootW:0]   root_p1;
  logic [CoordWidth-1:0] h;
  logic [CoordWidth-1:0] len;
  logic [CoordWidth-1:0] corner;
  logic             pre_mid;
  logic             odd;

  assign en             = !out_v || coord_ch.ready;
  assign index_ch.ready = en;

  sitc_isqrt_pipe #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_isqrt (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .idx_valid  (index_ch.valid),
    .index      (index_ch.index),
    .root_valid (root_valid),
    .root       (root),
    .rem        (rem)
  );

  // mid - n = root + 1 - rem, so no square is needed
  always_comb begin
    odd      = root[0];
    root_p1  = {1'b0, root} + 1'b1;
    pre_mid  = (rem <= root_p1);
    half_ext = ExtW'(root >> 1);
    len_ext  = pre_mid ? ExtW'(root_p1 - rem) : ExtW'(rem - root_p1);
    h        = half_ext[CoordWidth-1:0];
    len      = len_ext[CoordWidth-1:0];
    corner   = odd ? (h + 1'b1) : (~h + 1'b1);
    if (rem == '0) begin
      if (odd) begin
        x_next = coord_t'(~h + 1'b1);
        y_next = coord_t'(h);
      end else begin
        x_next = coord_t'(h);
        y_next = coord_t'(CoordWidth'(1) - h);
      end
    end else if (odd) begin
      x_next = pre_mid ? coord_t'(corner - len) : coord_t'(corner);
      y_next = pre_mid ? coord_t'(corner) : coord_t'(corner - len);
    end else begin
      x_next = pre_mid ? coord_t'(corner + len) : coord_t'(corner);
      y_next = pre_mid ? coord_t'(corner) : coord_t'(corner + len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= root_valid;
    end
    if (en) begin
      x_reg <= x_next;
      y_reg <= y_next;
    end
  end

  assign coord_ch.valid   = out_v;
  assign coord_ch.x_coord = x_reg;
  assign coord_ch.y_coord = y_reg;

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_v)
    else $error("output valid after reset");

  // a blocked result must hold back new transactions
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (out_v && !coord_ch.ready) |-> !index_ch.ready)
    else $error("input taken while output stalled");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_v && !coord_ch.ready) |=> (out_v && $stable(x_reg) && $stable(y_reg)))
    else $error("pending result lost");

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for spiral_index_to_coordinate_unit: predicts (x,y) per index
// depends on sitc_pkg, sitc_if and the unit rtl
`timescale 1ns / 1ps

module tb_top;
  import sitc_pkg::*;

  localparam int IndexWidth = 32;

  typedef struct {
    logic [IndexWidth-1:0] index;
    coord_t                x;
    coord_t                y;
  } spiral_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sitc_index_if #(.INDEX_WIDTH(IndexWidth)) index_ch ();
  sitc_coord_if coord_ch ();

  spiral_index_to_coordinate_unit #(
    .INDEX_WIDTH(IndexWidth)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .index_ch(index_ch),
    .coord_ch(coord_ch)
  );

  spiral_point_t expected_points[$];
  int            mismatches = 0;
  bit            idle_on = 1'b1;

  always #1 clk = ~clk;

  // grid position of an index on the square spiral, 1 at the origin
  function automatic spiral_point_t spiral_position(input logic [IndexWidth-1:0] idx);
    longint        n;
    longint        root;
    longint        cand;
    longint        mid;
    longint        leg_len;
    longint        half;
    longint        cx;
    longint        cy;
    spiral_point_t p;
    n    = longint'(idx);
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      cand = root | (longint'(1) << b);
      if (cand * cand <= n) root = cand;
    end
    if (root * root == n) begin
      if (root[0]) begin
        half = (root - 1) / 2;
        cx   = -half;
        cy   = half;
      end else begin
        half = root / 2;
        cx   = half;
        cy   = 1 - half;
      end
    end else begin
      mid     = root * root + root + 1;
      leg_len = (n >= mid) ? n - mid : mid - n;
      // odd root: corner at upper right, even root: corner at lower left
      if (root[0]) begin
        cx = (root + 1) / 2;
        cy = cx;
        if (n <= mid) cx -= leg_len;
        else cy -= leg_len;
      end else begin
        cx = -(root / 2);
        cy = cx;
        if (n <= mid) cx += leg_len;
        else cy += leg_len;
      end
    end
    p.index = idx;
    p.x     = cx[CoordWidth-1:0];
    p.y     = cy[CoordWidth-1:0];
    return p;
  endfunction

  // one index transaction, with an optional gap in front of it
  task automatic send_index(input logic [IndexWidth-1:0] idx);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      index_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    index_ch.valid <= 1'b1;
    index_ch.index <= idx;
    do @(posedge clk); while (!index_ch.ready);
    expected_points.push_back(spiral_position(idx));
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    while (expected_points.size() != 0) @(negedge clk);
  endtask

  // random index near a perfect square or a corner
  function automatic logic [IndexWidth-1:0] near_boundary();
    longint root;
    longint base;
    root = ($urandom_range(0, 1) == 0) ? longint'($urandom_range(0, 300))
                                       : longint'($urandom_range(0, 65535));
    base = ($urandom_range(0, 1) == 0) ? root * root : root * root + root + 1;
    base = base + longint'($urandom_range(0, 4)) - 2;
    if (base < 0) base = 0;
    if (base > 64'hFFFF_FFFF) base = 64'hFFFF_FFFF;
    return base[IndexWidth-1:0];
  endfunction

  task automatic test_directed();
    logic [IndexWidth-1:0] picks[$];
    picks = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9,
              32'd10, 32'd13, 32'd16, 32'd21, 32'd25, 32'd31, 32'd36,
              32'hFFFE_0001, 32'hFFFE_0000, 32'hFFFE_FFFF, 32'hFFFF_0000,
              32'hFFFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555};
    foreach (picks[i]) send_index(picks[i]);
  endtask

  task automatic test_full_range(input int count);
    repeat (count) send_index($urandom);
  endtask

  task automatic test_small_indices(input int count);
    repeat (count) send_index($urandom_range(0, 1200));
  endtask

  task automatic test_square_boundaries(input int count);
    repeat (count) send_index(near_boundary());
  endtask

  task automatic test_bit_walk();
    for (int b = 0; b < IndexWidth; b++) begin
      send_index(32'd1 << b);
      send_index(~(32'd1 << b));
    end
  endtask

  // hold off the sender until the pipeline is empty, then resume
  task automatic test_drain_pause(input int count);
    index_ch.valid <= 1'b0;
    wait_results_drained();
    repeat (count) send_index(near_boundary());
  endtask

  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    repeat (count) begin
      case ($urandom_range(0, 2))
        0:       send_index($urandom);
        1:       send_index($urandom_range(0, 1200));
        default: send_index(near_boundary());
      endcase
    end
  endtask

  // result side: random stall bursts while idling is on
  initial begin
    int run;
    coord_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        run = $urandom_range(1, 14);
        coord_ch.ready <= 1'b0;
      end else begin
        run = $urandom_range(1, 20);
        coord_ch.ready <= 1'b1;
      end
      repeat (run - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    spiral_point_t exp_pt;
    if (!rst && coord_ch.valid && coord_ch.ready) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time, coord_ch.x_coord,
                 coord_ch.y_coord);
        mismatches++;
      end else begin
        exp_pt = expected_points.pop_front();
        if (coord_ch.x_coord !== exp_pt.x) begin
          $display("%0t: index %0d x expected %0d actual %0d", $time, exp_pt.index,
                   exp_pt.x, coord_ch.x_coord);
          mismatches++;
        end
        if (coord_ch.y_coord !== exp_pt.y) begin
          $display("%0t: index %0d y expected %0d actual %0d", $time, exp_pt.index,
                   exp_pt.y, coord_ch.y_coord);
          mismatches++;
        end
      end
    end
  end

  initial begin
    index_ch.valid <= 1'b0;
    index_ch.index <= '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_full_range(500);
    test_small_indices(400);
    test_bit_walk();
    test_square_boundaries(400);
    test_drain_pause(200);
    test_back_to_back(400);
    index_ch.valid <= 1'b0;
    wait_results_drained();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
